/* rtl/mtm_pkg.sv */
// Shared constants and types for the median-then-mode sample filter.
package mtm_pkg;

  localparam int DEF_WIN1        = 5;
  localparam int DEF_WIN2        = 8;
  localparam int DEF_SAMPLE_BITS = 12;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MED  = 4'b0010,
    ST_MODE = 4'b0100,
    ST_HOLD = 4'b1000
  } mtm_state_t;

endpackage

/* rtl/median_then_mode_sample_filter.sv */
// Sliding median followed by sliding mode over a stream of converter samples.
// One item is in work at a time: the input stalls from its transfer until the
// result is loaded into the output register. A single comparator visits every
// window pair, first for each median candidate and then for each mode candidate.
// A stalled result holds the block. Synchronous reset zeroes both windows.
module median_then_mode_sample_filter
  import mtm_pkg::*;
#(
  parameter int WIN1        = DEF_WIN1,
  parameter int WIN2        = DEF_WIN2,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  output logic [SAMPLE_BITS-1:0] filtered,
  output logic                   filtered_valid,
  input  logic                   filtered_stall
);

  localparam int LMAX = (WIN1 > WIN2) ? WIN1 : WIN2;
  localparam int IW   = $clog2(LMAX);
  localparam int JW   = $clog2(LMAX + 1);
  localparam int CW1  = $clog2(WIN1 + 1);
  localparam int CW2  = $clog2(WIN2 + 1);
  localparam int K    = WIN1 / 2;

  mtm_state_t state;

  logic [SAMPLE_BITS-1:0] sw [WIN1];
  logic [SAMPLE_BITS-1:0] mw [WIN2];

  logic [IW-1:0]          i;
  logic [JW-1:0]          j;
  logic [SAMPLE_BITS-1:0] cand;
  logic [SAMPLE_BITS-1:0] med;
  logic [SAMPLE_BITS-1:0] best_val;
  logic [CW1-1:0]         lt_cnt;
  logic [CW1-1:0]         le_cnt;
  logic [CW2-1:0]         eq_cnt;
  logic [CW2-1:0]         best_cnt;

  logic [SAMPLE_BITS-1:0] cmp_a;
  logic [SAMPLE_BITS-1:0] cmp_b;
  logic                   cmp_lt;
  logic                   cmp_eq;
  logic                   in_xfer;
  logic                   out_free;
  logic                   med_hit;
  logic                   mode_upd;
  logic [SAMPLE_BITS-1:0] med_final;
  logic [SAMPLE_BITS-1:0] mode_final;

  assign sample_stall = (state != ST_IDLE);
  assign in_xfer      = sample_valid && !sample_stall;
  assign out_free     = !filtered_valid || !filtered_stall;

  // Shared comparator operand select
  always_comb begin
    cmp_a = sw[0];
    cmp_b = (j == '0) ? sw[0] : cand;
    if (state == ST_MODE) begin
      cmp_a = (j == JW'(WIN2)) ? best_val : mw[0];
      cmp_b = (j == '0) ? mw[0] : cand;
    end
  end

  assign cmp_lt = cmp_a < cmp_b;
  assign cmp_eq = cmp_a == cmp_b;

  // Candidate decisions at the end of each outer pass
  assign med_hit    = (lt_cnt <= CW1'(K)) && (le_cnt > CW1'(K));
  assign med_final  = med_hit ? cand : med;
  assign mode_upd   = (eq_cnt > best_cnt) ||
                      ((eq_cnt == best_cnt) && !cmp_lt && !cmp_eq);
  assign mode_final = mode_upd ? cand : best_val;

  // Sequencer and window storage
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      filtered_valid <= 1'b0;
      i              <= '0;
      j              <= '0;
      for (int k = 0; k < WIN1; k++) sw[k] <= '0;
      for (int k = 0; k < WIN2; k++) mw[k] <= '0;
    end else begin
      // Load a finished result, or drop it once it transfers
      if ((state == ST_HOLD) && out_free) begin
        filtered_valid <= 1'b1;
      end else if (filtered_valid && !filtered_stall) begin
        filtered_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            for (int k = 0; k < WIN1 - 1; k++) sw[k] <= sw[k+1];
            sw[WIN1-1] <= sample;
            i          <= '0;
            j          <= '0;
            state      <= ST_MED;
          end
        end

        ST_MED: begin
          // Rotate the sample window past the comparator every cycle
          for (int k = 0; k < WIN1 - 1; k++) sw[k] <= sw[k+1];
          sw[WIN1-1] <= sw[0];
          if (j == '0) begin
            cand   <= sw[0];
            lt_cnt <= CW1'(cmp_lt);
            le_cnt <= CW1'(cmp_lt || cmp_eq);
            j      <= j + 1'b1;
          end else if (j != JW'(WIN1)) begin
            lt_cnt <= lt_cnt + CW1'(cmp_lt);
            le_cnt <= le_cnt + CW1'(cmp_lt || cmp_eq);
            j      <= j + 1'b1;
          end else begin
            med <= med_final;
            j   <= '0;
            if (i == IW'(WIN1 - 1)) begin
              // Push the median into the mode window
              for (int k = 0; k < WIN2 - 1; k++) mw[k] <= mw[k+1];
              mw[WIN2-1] <= med_final;
              best_cnt   <= '0;
              best_val   <= '0;
              i          <= '0;
              state      <= ST_MODE;
            end else begin
              i <= i + 1'b1;
            end
          end
        end

        ST_MODE: begin
          // Rotate the median window past the comparator every cycle
          for (int k = 0; k < WIN2 - 1; k++) mw[k] <= mw[k+1];
          mw[WIN2-1] <= mw[0];
          if (j == '0) begin
            cand   <= mw[0];
            eq_cnt <= CW2'(cmp_eq);
            j      <= j + 1'b1;
          end else if (j != JW'(WIN2)) begin
            eq_cnt <= eq_cnt + CW2'(cmp_eq);
            j      <= j + 1'b1;
          end else begin
            best_val <= mode_final;
            if (mode_upd) best_cnt <= eq_cnt;
            j <= '0;
            if (i == IW'(WIN2 - 1)) begin
              i     <= '0;
              state <= ST_HOLD;
            end else begin
              i <= i + 1'b1;
            end
          end
        end

        ST_HOLD: begin
          // Load the output register once it is free
          if (out_free) begin
            filtered <= best_val;
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks on the sequencer
  a_accept_starts_median: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == ST_MED)
    else $error("input transfer did not start the median pass");

  a_hold_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) && out_free |=> filtered_valid && (state == ST_IDLE))
    else $error("result not loaded when output register was free");

  a_med_bounds: assert property (@(posedge clk) disable iff (rst)
    state == ST_MED |-> (j <= JW'(WIN1)) && (i <= IW'(WIN1 - 1)))
    else $error("median counters out of range");

  a_mode_bounds: assert property (@(posedge clk) disable iff (rst)
    state == ST_MODE |-> (j <= JW'(WIN2)) && (i <= IW'(WIN2 - 1)))
    else $error("mode counters out of range");

endmodule

/* tb/sv/tb_median_then_mode_sample_filter.sv */
// Self-checking testbench for the median-then-mode sample filter.
module tb_median_then_mode_sample_filter;
  import mtm_pkg::*;

  localparam int WIN1        = DEF_WIN1;
  localparam int WIN2        = DEF_WIN2;
  localparam int SB          = DEF_SAMPLE_BITS;
  localparam int LATENCY     = WIN1 * (WIN1 + 1) + WIN2 * (WIN2 + 1) + 2;
  localparam int CYCLE_LIMIT = 800000;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASE_ITEMS = 180;

  localparam logic [SB-1:0] VAL_MIN = '0;
  localparam logic [SB-1:0] VAL_MAX = '1;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic [SB-1:0] sample = '0;
  logic          sample_valid = 1'b0;
  logic          sample_stall;
  logic [SB-1:0] filtered;
  logic          filtered_valid;
  logic          filtered_stall = 1'b0;

  // Queues of samples to send and filtered values still owed by the block
  logic [SB-1:0] pending_samples [$];
  logic [SB-1:0] expected_filtered [$];

  // Predictor state: sample history and median history, oldest first
  logic [SB-1:0] sample_hist [WIN1];
  logic [SB-1:0] median_hist [WIN2];

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_request = 1'b0;
  logic hold_rx = 1'b0;
  logic sample_taken = 1'b0;
  int   mismatches = 0;
  int   cycle_count = 0;

  median_then_mode_sample_filter #(
    .WIN1(WIN1),
    .WIN2(WIN2),
    .SAMPLE_BITS(SB)
  ) dut (
    .clk(clk),
    .rst(rst),
    .sample(sample),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .filtered(filtered),
    .filtered_valid(filtered_valid),
    .filtered_stall(filtered_stall)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("[%0d] mismatch: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Shift a sample into both windows and return the smallest most frequent median
  function automatic logic [SB-1:0] advance_filter(input logic [SB-1:0] s);
    logic [SB-1:0] sorted [WIN1];
    logic [SB-1:0] key;
    logic [SB-1:0] best_val;
    int j;
    int cnt;
    int best_cnt;
    for (int i = 1; i < WIN1; i++) sample_hist[i-1] = sample_hist[i];
    sample_hist[WIN1-1] = s;
    sorted = sample_hist;
    for (int i = 1; i < WIN1; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    for (int i = 1; i < WIN2; i++) median_hist[i-1] = median_hist[i];
    median_hist[WIN2-1] = sorted[WIN1/2];
    best_val = '0;
    best_cnt = 0;
    for (int i = 0; i < WIN2; i++) begin
      cnt = 0;
      for (int k = 0; k < WIN2; k++)
        if (median_hist[k] == median_hist[i]) cnt++;
      if (cnt > best_cnt || (cnt == best_cnt && median_hist[i] < best_val)) begin
        best_cnt = cnt;
        best_val = median_hist[i];
      end
    end
    return best_val;
  endfunction

  // Queue a phase of random samples: mostly runs drawn from a small value pool,
  // so medians repeat and the mode has real ties to resolve; the rest is noise
  task automatic queue_random_phase(input int count);
    logic [SB-1:0] pool [4];
    logic [SB-1:0] v;
    int run;
    int kind;
    int n;
    foreach (pool[i]) pool[i] = SB'($urandom);
    n = 0;
    while (n < count) begin
      kind = $urandom_range(99);
      if (kind < 65) begin
        v = pool[$urandom_range(3)];
        run = $urandom_range(5, 1);
      end else if (kind < 85) begin
        v = SB'($urandom);
        run = 1;
      end else begin
        v = $urandom_range(1) ? VAL_MAX : VAL_MIN;
        run = $urandom_range(3, 1);
      end
      for (int r = 0; r < run; r++) pending_samples.push_back(v);
      n += run;
    end
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || expected_filtered.size() != 0)
      @(posedge clk);
  endtask

  // Drive the sample channel: hold a stalled transfer, otherwise offer the next one
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      sample <= '0;
    end else if (!sample_valid || sample_taken) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        sample <= pending_samples.pop_front();
        sample_valid <= 1'b1;
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Drive the result stall: long hold-off when requested, random otherwise
  always @(negedge clk) begin
    if (rst) filtered_stall <= 1'b0;
    else filtered_stall <= hold_rx || ($urandom_range(99) < recv_idle_pct);
  end

  // Predict on every sample transfer and check every result transfer
  always @(posedge clk) begin
    if (rst) begin
      foreach (sample_hist[i]) sample_hist[i] = '0;
      foreach (median_hist[i]) median_hist[i] = '0;
      sample_taken <= 1'b0;
    end else begin
      sample_taken <= sample_valid && !sample_stall;
      if (sample_valid && !sample_stall)
        expected_filtered.push_back(advance_filter(sample));
      if (filtered_valid && !filtered_stall) begin
        if (expected_filtered.size() == 0)
          report_mismatch($sformatf("unexpected result %0d", filtered));
        else if (filtered !== expected_filtered[0]) begin
          report_mismatch($sformatf("filtered %0d, predicted %0d",
                                    filtered, expected_filtered[0]));
          void'(expected_filtered.pop_front());
        end else begin
          void'(expected_filtered.pop_front());
        end
      end
    end
  end

  // Hold off the receiver for a long stretch so the block backs up its input
  initial begin
    while (!hold_request) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, alternating bits, and runs that tie medians in frequency
    pending_samples = '{12'd0, 12'hFFF, 12'hAAA, 12'h555, 12'hFFF, 12'd0, 12'hFFF,
                        12'h800, 12'h800, 12'h800, 12'h7FF, 12'h7FF, 12'h7FF,
                        12'd1, 12'd1, 12'd1, 12'hFFE, 12'hFFE, 12'hFFE,
                        12'hFFF, 12'hFFF, 12'hFFF, 12'd0, 12'd0, 12'd0};
    wait_drained();

    // Slow receiver
    send_idle_pct = 18;
    recv_idle_pct = 84;
    queue_random_phase(PHASE_ITEMS);
    wait_drained();

    // Slow sender
    send_idle_pct = 84;
    recv_idle_pct = 18;
    queue_random_phase(PHASE_ITEMS);
    wait_drained();

    // Full rate, starting with a long receiver hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_phase(PHASE_ITEMS);
    hold_request = 1'b1;
    wait_drained();

    repeat (2 * LATENCY) @(posedge clk);
    if (expected_filtered.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_filtered.size()));
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* median_then_mode_sample_filter.f */
rtl/mtm_pkg.sv
rtl/median_then_mode_sample_filter.sv
tb/sv/tb_median_then_mode_sample_filter.sv
